### rtl/core/pchc_pkg.sv
// Shared types, constants and arithmetic helpers for the point cloud height crop filter.
`timescale 1ns / 1ps

package pchc_pkg;

   localparam int POS_W      = 17;
   localparam int DIFF_W     = 18;
   localparam int BELT_W     = 18;
   localparam int QUAT_W     = 16;
   localparam int SHIFT_W    = 17;
   localparam int COUNT_W    = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;
   localparam int TERM_W     = 17;
   localparam int QPROD_W    = 32;
   localparam int ENTRY_W    = 36;
   localparam int PROD_W     = TERM_W + DIFF_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int FRAC_BITS  = 14;

   localparam int NUM_TERMS  = 9;
   localparam int TERM_IDX_W = $clog2(NUM_TERMS);
   localparam int STEP_W     = $clog2(NUM_TERMS + 1);
   localparam int NUM_ROWS   = 3;

   localparam int MAX_FRAME_POINTS = 262144;
   localparam int COUNT_LIMIT = (MAX_FRAME_POINTS > 524287) ? 524287 : MAX_FRAME_POINTS;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_LIMIT);

   localparam logic signed [POS_W-1:0]  DEPTH_LO  = 17'sd7782;
   localparam logic signed [POS_W-1:0]  DEPTH_HI  = 17'sd12944;
   localparam logic signed [BELT_W-1:0] HEIGHT_LO = 18'sd368;
   localparam logic signed [BELT_W-1:0] HEIGHT_HI = 18'sd2868;

   localparam logic signed [QUAT_W-1:0]     QUAT_W_RESET   = 16'sd16384;
   localparam logic [COUNT_W-1:0]           MIN_PTS_RESET  = 19'd800;
   localparam logic signed [TERM_W-1:0]     TERM_ONE       = 17'sd16384;
   localparam logic signed [ENTRY_W-1:0]    ENTRY_ONE      = 36'sd268435456;
   localparam logic signed [ENTRY_W-1:0]    ENTRY_HALF     = 36'sd8192;
   localparam logic signed [ENTRY_W-1:0]    ENTRY_MAX      = 36'sd65535;
   localparam logic signed [ENTRY_W-1:0]    ENTRY_MIN      = -36'sd65536;
   localparam logic signed [ACC_W-1:0]      ACC_HALF       = 37'sd8192;
   localparam logic signed [ACC_W-1:0]      ACC_MAX        = 37'sd131071;
   localparam logic signed [ACC_W-1:0]      ACC_MIN        = -37'sd131072;

   typedef enum logic [2:0] {
      CSR_QUAT_W,
      CSR_QUAT_X,
      CSR_QUAT_Y,
      CSR_QUAT_Z,
      CSR_SHIFT_X,
      CSR_SHIFT_Y,
      CSR_SHIFT_Z,
      CSR_MIN_POINTS
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DRAIN,
      ST_FINISH,
      ST_REBUILD
   } state_type;

   typedef enum logic [1:0] {
      ENTRY_DIAG,
      ENTRY_SUM,
      ENTRY_DIFF
   } entry_mode_type;

   typedef struct packed {
      logic                  accept;
      logic                  row_issue;
      logic                  term_issue;
      logic [TERM_IDX_W-1:0] term_idx;
      logic                  finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic entry_mode_type entry_mode(input logic [TERM_IDX_W-1:0] idx);
      entry_mode_type mode;
      unique case (idx) inside
         4'd0, 4'd4, 4'd8: mode = ENTRY_DIAG;
         4'd1, 4'd5, 4'd6: mode = ENTRY_SUM;
         default:          mode = ENTRY_DIFF;
      endcase
      return mode;
   endfunction

   function automatic logic signed [TERM_W-1:0] term_round(
      input logic signed [ENTRY_W-1:0] v);
      logic signed [ENTRY_W-1:0] r;
      logic signed [ENTRY_W-1:0] s;
      r = (v + ENTRY_HALF) >>> FRAC_BITS;
      if (r > ENTRY_MAX) begin
         s = ENTRY_MAX;
      end else if (r < ENTRY_MIN) begin
         s = ENTRY_MIN;
      end else begin
         s = r;
      end
      return s[TERM_W-1:0];
   endfunction

   function automatic logic signed [BELT_W-1:0] belt_round(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] s;
      r = (v + ACC_HALF) >>> FRAC_BITS;
      if (r > ACC_MAX) begin
         s = ACC_MAX;
      end else if (r < ACC_MIN) begin
         s = ACC_MIN;
      end else begin
         s = r;
      end
      return s[BELT_W-1:0];
   endfunction

endpackage

### rtl/core/pchc_ctrl.sv
// Controller state machine that sequences point transactions and matrix rebuilds.
`timescale 1ns / 1ps

module pchc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            csr_write_en,
   input  logic [pchc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  pchc_pkg::dp_status_type         status,
   output pchc_pkg::dp_cmd_type            cmd
);

   pchc_pkg::state_type               state_ff, state_in;
   logic [pchc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                              quat_write;
   logic                              accept;

   always_comb begin
      quat_write = 1'b0;
      if (csr_write_en) begin
         case (pchc_pkg::csr_reg_type'(csr_index)) inside
            pchc_pkg::CSR_QUAT_W, pchc_pkg::CSR_QUAT_X,
            pchc_pkg::CSR_QUAT_Y, pchc_pkg::CSR_QUAT_Z: quat_write = 1'b1;
            default:                                    quat_write = 1'b0;
         endcase
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         pchc_pkg::ST_IDLE: begin
            if (quat_write) begin
               state_in = pchc_pkg::ST_REBUILD;
               step_in  = '0;
            end else if (accept) begin
               state_in = pchc_pkg::ST_ROTATE;
               step_in  = '0;
            end
         end
         pchc_pkg::ST_ROTATE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == pchc_pkg::STEP_W'(pchc_pkg::NUM_ROWS - 1)) begin
               state_in = pchc_pkg::ST_DRAIN;
            end
         end
         pchc_pkg::ST_DRAIN: begin
            state_in = pchc_pkg::ST_FINISH;
         end
         pchc_pkg::ST_FINISH: begin
            if (status.out_free) begin
               step_in = '0;
               if (accept) begin
                  state_in = pchc_pkg::ST_ROTATE;
               end else begin
                  state_in = pchc_pkg::ST_IDLE;
               end
            end
         end
         pchc_pkg::ST_REBUILD: begin
            if (quat_write) begin
               step_in = '0;
            end else if (step_ff == pchc_pkg::STEP_W'(pchc_pkg::NUM_TERMS)) begin
               state_in = pchc_pkg::ST_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = pchc_pkg::ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pchc_pkg::ST_IDLE: begin
            req_ready = !csr_write_en;
         end
         pchc_pkg::ST_ROTATE: begin
            cmd.row_issue = 1'b1;
         end
         pchc_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         pchc_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               req_ready  = !csr_write_en;
            end
         end
         pchc_pkg::ST_REBUILD: begin
            if (step_ff < pchc_pkg::STEP_W'(pchc_pkg::NUM_TERMS)) begin
               cmd.term_issue = 1'b1;
               cmd.term_idx   = step_ff[pchc_pkg::TERM_IDX_W-1:0];
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
      cmd.accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pchc_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/core/pchc_dp.sv
// Datapath: configuration registers, rotation matrix, shift, rotate, crop and frame count.
`timescale 1ns / 1ps

module pchc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pchc_pkg::dp_cmd_type                   cmd,
   output pchc_pkg::dp_status_type                status,
   input  logic                                   csr_write_en,
   input  logic [pchc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pchc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_z,
   input  logic                                   req_point_valid,
   input  logic                                   req_frame_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_point_kept,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_x,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_y,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_z,
   output logic                                   rsp_frame_done,
   output logic                                   rsp_frame_accepted,
   output logic [pchc_pkg::COUNT_W-1:0]           rsp_frame_count
);

   localparam int NT = pchc_pkg::NUM_TERMS;

   logic signed [pchc_pkg::QUAT_W-1:0]  quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic signed [pchc_pkg::SHIFT_W-1:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [pchc_pkg::COUNT_W-1:0]        min_points_ff;

   logic signed [pchc_pkg::TERM_W-1:0]  mat_ff [NT];
   logic signed [pchc_pkg::TERM_W-1:0]  mat_in [NT];

   logic signed [pchc_pkg::QUAT_W-1:0]  op_a, op_b, op_c, op_d;
   logic signed [pchc_pkg::QPROD_W-1:0] qprod1_ff, qprod1_in, qprod2_ff, qprod2_in;
   logic                                qvalid_ff;
   logic [pchc_pkg::TERM_IDX_W-1:0]     qidx_ff;
   logic signed [pchc_pkg::ENTRY_W-1:0] qsum, qentry;

   logic signed [pchc_pkg::DIFF_W-1:0]  diff_x_ff, diff_x_in;
   logic signed [pchc_pkg::DIFF_W-1:0]  diff_y_ff, diff_y_in;
   logic signed [pchc_pkg::DIFF_W-1:0]  diff_z_ff, diff_z_in;
   logic                                window_ff, window_in;
   logic                                last_ff;

   logic signed [pchc_pkg::PROD_W-1:0]  prod_ff [pchc_pkg::NUM_ROWS];
   logic signed [pchc_pkg::PROD_W-1:0]  prod_in [pchc_pkg::NUM_ROWS];
   logic                                prod_valid_ff;
   logic signed [pchc_pkg::ACC_W-1:0]   acc;
   logic signed [pchc_pkg::BELT_W-1:0]  belt_x_ff, belt_y_ff, belt_z_ff, belt_z_in;

   logic [pchc_pkg::COUNT_W-1:0]        kept_total_ff, kept_total_in;
   logic [pchc_pkg::COUNT_W-1:0]        count_next;
   logic                                kept;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kept_ff;
   logic signed [pchc_pkg::BELT_W-1:0]  rsp_bx_ff, rsp_by_ff, rsp_bz_ff;
   logic                                rsp_done_ff, rsp_acc_ff;
   logic [pchc_pkg::COUNT_W-1:0]        rsp_count_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff     <= pchc_pkg::QUAT_W_RESET;
         quat_x_ff     <= '0;
         quat_y_ff     <= '0;
         quat_z_ff     <= '0;
         shift_x_ff    <= '0;
         shift_y_ff    <= '0;
         shift_z_ff    <= '0;
         min_points_ff <= pchc_pkg::MIN_PTS_RESET;
      end else if (csr_write_en) begin
         unique case (pchc_pkg::csr_reg_type'(csr_index))
            pchc_pkg::CSR_QUAT_W:     quat_w_ff     <= csr_wdata[pchc_pkg::QUAT_W-1:0];
            pchc_pkg::CSR_QUAT_X:     quat_x_ff     <= csr_wdata[pchc_pkg::QUAT_W-1:0];
            pchc_pkg::CSR_QUAT_Y:     quat_y_ff     <= csr_wdata[pchc_pkg::QUAT_W-1:0];
            pchc_pkg::CSR_QUAT_Z:     quat_z_ff     <= csr_wdata[pchc_pkg::QUAT_W-1:0];
            pchc_pkg::CSR_SHIFT_X:    shift_x_ff    <= csr_wdata[pchc_pkg::SHIFT_W-1:0];
            pchc_pkg::CSR_SHIFT_Y:    shift_y_ff    <= csr_wdata[pchc_pkg::SHIFT_W-1:0];
            pchc_pkg::CSR_SHIFT_Z:    shift_z_ff    <= csr_wdata[pchc_pkg::SHIFT_W-1:0];
            pchc_pkg::CSR_MIN_POINTS: min_points_ff <= csr_wdata[pchc_pkg::COUNT_W-1:0];
            default:                  min_points_ff <= min_points_ff;
         endcase
      end
   end

   // Operand pairs for each matrix entry of the inverse rotation.
   always_comb begin
      case (cmd.term_idx)
         4'd0:    begin op_a = quat_y_ff; op_b = quat_y_ff; op_c = quat_z_ff; op_d = quat_z_ff; end
         4'd1:    begin op_a = quat_x_ff; op_b = quat_y_ff; op_c = quat_w_ff; op_d = quat_z_ff; end
         4'd2:    begin op_a = quat_x_ff; op_b = quat_z_ff; op_c = quat_w_ff; op_d = quat_y_ff; end
         4'd3:    begin op_a = quat_x_ff; op_b = quat_y_ff; op_c = quat_w_ff; op_d = quat_z_ff; end
         4'd4:    begin op_a = quat_x_ff; op_b = quat_x_ff; op_c = quat_z_ff; op_d = quat_z_ff; end
         4'd5:    begin op_a = quat_y_ff; op_b = quat_z_ff; op_c = quat_w_ff; op_d = quat_x_ff; end
         4'd6:    begin op_a = quat_x_ff; op_b = quat_z_ff; op_c = quat_w_ff; op_d = quat_y_ff; end
         4'd7:    begin op_a = quat_y_ff; op_b = quat_z_ff; op_c = quat_w_ff; op_d = quat_x_ff; end
         4'd8:    begin op_a = quat_x_ff; op_b = quat_x_ff; op_c = quat_y_ff; op_d = quat_y_ff; end
         default: begin op_a = '0;        op_b = '0;        op_c = '0;        op_d = '0;        end
      endcase
   end

   assign qprod1_in = pchc_pkg::QPROD_W'(op_a * op_b);
   assign qprod2_in = pchc_pkg::QPROD_W'(op_c * op_d);

   always_comb begin
      qsum   = '0;
      qentry = '0;
      case (pchc_pkg::entry_mode(qidx_ff))
         pchc_pkg::ENTRY_DIAG: begin
            qsum   = pchc_pkg::ENTRY_W'(qprod1_ff) + pchc_pkg::ENTRY_W'(qprod2_ff);
            qentry = pchc_pkg::ENTRY_ONE - (qsum <<< 1);
         end
         pchc_pkg::ENTRY_SUM: begin
            qsum   = pchc_pkg::ENTRY_W'(qprod1_ff) + pchc_pkg::ENTRY_W'(qprod2_ff);
            qentry = qsum <<< 1;
         end
         default: begin
            qsum   = pchc_pkg::ENTRY_W'(qprod1_ff) - pchc_pkg::ENTRY_W'(qprod2_ff);
            qentry = qsum <<< 1;
         end
      endcase
   end

   // The matrix rotates by one row per multiply step so the columns are read at fixed places.
   always_comb begin
      for (int k = 0; k < NT; k++) begin
         mat_in[k] = mat_ff[k];
      end
      if (cmd.row_issue) begin
         for (int k = 0; k < NT - pchc_pkg::NUM_ROWS; k++) begin
            mat_in[k] = mat_ff[k + pchc_pkg::NUM_ROWS];
         end
         for (int k = NT - pchc_pkg::NUM_ROWS; k < NT; k++) begin
            mat_in[k] = mat_ff[k - (NT - pchc_pkg::NUM_ROWS)];
         end
      end
      if (qvalid_ff) begin
         mat_in[qidx_ff] = pchc_pkg::term_round(qentry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NT; k++) begin
            mat_ff[k] <= (k == 0 || k == pchc_pkg::NUM_ROWS + 1
                          || k == 2 * (pchc_pkg::NUM_ROWS + 1)) ? pchc_pkg::TERM_ONE : '0;
         end
         qvalid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NT; k++) begin
            mat_ff[k] <= mat_in[k];
         end
         qvalid_ff <= cmd.term_issue;
      end
   end

   always_ff @(posedge clock) begin
      qprod1_ff <= qprod1_in;
      qprod2_ff <= qprod2_in;
      qidx_ff   <= cmd.term_idx;
   end

   // Input capture: shifted point and depth window.
   assign diff_x_in = pchc_pkg::DIFF_W'(req_pos_x) - pchc_pkg::DIFF_W'(shift_x_ff);
   assign diff_y_in = pchc_pkg::DIFF_W'(req_pos_y) - pchc_pkg::DIFF_W'(shift_y_ff);
   assign diff_z_in = pchc_pkg::DIFF_W'(req_pos_z) - pchc_pkg::DIFF_W'(shift_z_ff);
   assign window_in = req_point_valid && (req_pos_z > pchc_pkg::DEPTH_LO)
                      && (req_pos_z < pchc_pkg::DEPTH_HI);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         diff_x_ff <= diff_x_in;
         diff_y_ff <= diff_y_in;
         diff_z_ff <= diff_z_in;
         window_ff <= window_in;
         last_ff   <= req_frame_last;
      end
   end

   // One matrix row per cycle, summed and rounded in the following cycle.
   assign prod_in[0] = pchc_pkg::PROD_W'(mat_ff[0] * diff_x_ff);
   assign prod_in[1] = pchc_pkg::PROD_W'(mat_ff[1] * diff_y_ff);
   assign prod_in[2] = pchc_pkg::PROD_W'(mat_ff[2] * diff_z_ff);

   assign acc = pchc_pkg::ACC_W'(prod_ff[0]) + pchc_pkg::ACC_W'(prod_ff[1])
                + pchc_pkg::ACC_W'(prod_ff[2]);
   assign belt_z_in = pchc_pkg::belt_round(acc);

   always_ff @(posedge clock) begin
      for (int j = 0; j < pchc_pkg::NUM_ROWS; j++) begin
         prod_ff[j] <= prod_in[j];
      end
      if (prod_valid_ff) begin
         belt_x_ff <= belt_y_ff;
         belt_y_ff <= belt_z_ff;
         belt_z_ff <= belt_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.row_issue;
      end
   end

   // Height crop and frame count.
   assign kept = window_ff && (belt_z_ff > pchc_pkg::HEIGHT_LO)
                 && (belt_z_ff < pchc_pkg::HEIGHT_HI);
   assign count_next = (kept && (kept_total_ff < pchc_pkg::COUNT_CAP))
                       ? kept_total_ff + 1'b1 : kept_total_ff;

   always_comb begin
      kept_total_in = kept_total_ff;
      if (cmd.finish) begin
         kept_total_in = last_ff ? '0 : count_next;
      end
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         kept_total_ff <= kept_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_kept_ff  <= kept;
         rsp_bx_ff    <= window_ff ? belt_x_ff : '0;
         rsp_by_ff    <= window_ff ? belt_y_ff : '0;
         rsp_bz_ff    <= window_ff ? belt_z_ff : '0;
         rsp_done_ff  <= last_ff;
         rsp_acc_ff   <= last_ff && (count_next > min_points_ff);
         rsp_count_ff <= count_next;
      end
   end

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_kept     = rsp_kept_ff;
   assign rsp_belt_x         = rsp_bx_ff;
   assign rsp_belt_y         = rsp_by_ff;
   assign rsp_belt_z         = rsp_bz_ff;
   assign rsp_frame_done     = rsp_done_ff;
   assign rsp_frame_accepted = rsp_acc_ff;
   assign rsp_frame_count    = rsp_count_ff;

endmodule

### rtl/core/point_cloud_height_crop_filter.sv
// Top level of the point cloud height crop filter: controller, datapath and checks.
`timescale 1ns / 1ps

// The req channel takes one camera-frame point per transaction (position, valid flag and
// end-of-frame flag); the rsp channel returns exactly one result per point: keep flag,
// conveyor-frame coordinates, the running kept count and, on the last point of a frame,
// the frame verdict. Both channels use valid/ready.
// From acceptance to rsp_valid a point goes one matrix row at a time through three
// parallel multipliers, then a step sums the last row and a final step crops and counts.
// The next point is accepted in the cycle its predecessor is written to the output
// register, so a new point is taken only once the previous one is finished.
// Writing a quaternion register rebuilds the 9-entry rotation matrix through a shared
// pair of multipliers, during which req_ready is low. Other registers take
// effect at once. Configure only while no transaction is in flight.
// Reset loads the identity rotation and the register defaults and clears the frame count.
// When rsp_ready is held low, the finished result waits in the output register while the
// next point is already processed; that point then waits in the datapath and req_ready
// stays low until the output register frees up.

module point_cloud_height_crop_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pchc_pkg::POS_W-1:0]      req_pos_z,
   input  logic                                   req_point_valid,
   input  logic                                   req_frame_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_point_kept,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_x,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_y,
   output logic signed [pchc_pkg::BELT_W-1:0]     rsp_belt_z,
   output logic                                   rsp_frame_done,
   output logic                                   rsp_frame_accepted,
   output logic [pchc_pkg::COUNT_W-1:0]           rsp_frame_count,
   input  logic                                   csr_write_en,
   input  logic [pchc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pchc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   pchc_pkg::dp_cmd_type    cmd;
   pchc_pkg::dp_status_type status;

   pchc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .status       (status),
      .cmd          (cmd)
   );

   pchc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_point_valid    (req_point_valid),
      .req_frame_last     (req_frame_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_point_kept     (rsp_point_kept),
      .rsp_belt_x         (rsp_belt_x),
      .rsp_belt_y         (rsp_belt_y),
      .rsp_belt_z         (rsp_belt_z),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_frame_count    (rsp_frame_count)
   );

   // A frame verdict is only reported on the last point of a frame.
   a_accept_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> !rsp_frame_accepted)
      else $error("frame accepted without frame end");

   // A kept point lies inside the height window.
   a_kept_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_kept |->
         (rsp_belt_z > pchc_pkg::HEIGHT_LO) && (rsp_belt_z < pchc_pkg::HEIGHT_HI))
      else $error("kept point outside height window");

   // After a point is taken, req_ready is low in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted back to back");

   // The frame count never passes its cap.
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_count <= pchc_pkg::COUNT_CAP)
      else $error("frame count above cap");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the point cloud height crop filter: directed and random points.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DEPTH_FLOOR  = 7782;
   localparam int DEPTH_CEIL   = 12944;
   localparam int HEIGHT_FLOOR = 368;
   localparam int HEIGHT_CEIL  = 2868;
   localparam int PHASES       = 8;
   localparam int PHASE_POINTS = 210;

   typedef struct packed {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [16:0] pz;
      logic               valid;
      logic               last;
   } camera_point_type;

   typedef struct packed {
      logic               kept;
      logic signed [17:0] belt_x;
      logic signed [17:0] belt_y;
      logic signed [17:0] belt_z;
      logic               done;
      logic               accepted;
      logic [18:0]        count;
   } belt_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [16:0] req_pos_x;
   logic signed [16:0] req_pos_y;
   logic signed [16:0] req_pos_z;
   logic               req_point_valid;
   logic               req_frame_last;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_point_kept;
   logic signed [17:0] rsp_belt_x;
   logic signed [17:0] rsp_belt_y;
   logic signed [17:0] rsp_belt_z;
   logic               rsp_frame_done;
   logic               rsp_frame_accepted;
   logic [18:0]        rsp_frame_count;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [18:0]        csr_wdata;

   logic signed [15:0] quat_w_set;
   logic signed [15:0] quat_x_set;
   logic signed [15:0] quat_y_set;
   logic signed [15:0] quat_z_set;
   logic signed [16:0] shift_x_set;
   logic signed [16:0] shift_y_set;
   logic signed [16:0] shift_z_set;
   logic [18:0]        min_points_set;
   logic [18:0]        frame_kept;
   longint             rotation [9];

   belt_result_type expected_belt_results [$];
   int              mismatch_count;
   int              cycle_count;
   int              rx_stall_left;
   int              rx_hold_request;
   bit              rx_idle_on;
   bit              tx_idle_on;

   point_cloud_height_crop_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_point_valid    (req_point_valid),
      .req_frame_last     (req_frame_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_point_kept     (rsp_point_kept),
      .rsp_belt_x         (rsp_belt_x),
      .rsp_belt_y         (rsp_belt_y),
      .rsp_belt_z         (rsp_belt_z),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_frame_count    (rsp_frame_count),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic longint q14_round(input longint v);
      return (v + 64'sd8192) >>> 14;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint matrix_entry(input longint q28);
      return clamp(q14_round(q28), -65536, 65535);
   endfunction

   function automatic void rebuild_rotation();
      longint w, x, y, z, one;
      w = quat_w_set;
      x = quat_x_set;
      y = quat_y_set;
      z = quat_z_set;
      one = 64'sd268435456;
      rotation[0] = matrix_entry(one - 2 * (y * y + z * z));
      rotation[1] = matrix_entry(2 * (x * y + w * z));
      rotation[2] = matrix_entry(2 * (x * z - w * y));
      rotation[3] = matrix_entry(2 * (x * y - w * z));
      rotation[4] = matrix_entry(one - 2 * (x * x + z * z));
      rotation[5] = matrix_entry(2 * (y * z + w * x));
      rotation[6] = matrix_entry(2 * (x * z + w * y));
      rotation[7] = matrix_entry(2 * (y * z - w * x));
      rotation[8] = matrix_entry(one - 2 * (x * x + y * y));
   endfunction

   function automatic void restore_defaults();
      quat_w_set = 16'sd16384;
      quat_x_set = '0;
      quat_y_set = '0;
      quat_z_set = '0;
      shift_x_set = '0;
      shift_y_set = '0;
      shift_z_set = '0;
      min_points_set = 19'd800;
      frame_kept = '0;
      rebuild_rotation();
   endfunction

   function automatic void apply_setting(input pchc_pkg::csr_reg_type which,
                                         input logic [18:0] value);
      case (which)
         pchc_pkg::CSR_QUAT_W: begin
            quat_w_set = value[15:0];
            rebuild_rotation();
         end
         pchc_pkg::CSR_QUAT_X: begin
            quat_x_set = value[15:0];
            rebuild_rotation();
         end
         pchc_pkg::CSR_QUAT_Y: begin
            quat_y_set = value[15:0];
            rebuild_rotation();
         end
         pchc_pkg::CSR_QUAT_Z: begin
            quat_z_set = value[15:0];
            rebuild_rotation();
         end
         pchc_pkg::CSR_SHIFT_X:    shift_x_set = value[16:0];
         pchc_pkg::CSR_SHIFT_Y:    shift_y_set = value[16:0];
         pchc_pkg::CSR_SHIFT_Z:    shift_z_set = value[16:0];
         pchc_pkg::CSR_MIN_POINTS: min_points_set = value;
         default: ;
      endcase
   endfunction

   function automatic belt_result_type predict_crop(input camera_point_type p);
      belt_result_type r;
      longint d [3];
      longint b [3];
      longint acc;
      logic kept;
      int i;
      b[0] = 0;
      b[1] = 0;
      b[2] = 0;
      kept = 1'b0;
      if (p.valid && p.pz > DEPTH_FLOOR && p.pz < DEPTH_CEIL) begin
         d[0] = longint'(p.px) - longint'(shift_x_set);
         d[1] = longint'(p.py) - longint'(shift_y_set);
         d[2] = longint'(p.pz) - longint'(shift_z_set);
         for (i = 0; i < 3; i++) begin
            acc = rotation[3 * i] * d[0] + rotation[3 * i + 1] * d[1]
                + rotation[3 * i + 2] * d[2];
            b[i] = clamp(q14_round(acc), -131072, 131071);
         end
         kept = (b[2] > HEIGHT_FLOOR) && (b[2] < HEIGHT_CEIL);
      end
      if (kept && frame_kept < pchc_pkg::COUNT_CAP) frame_kept++;
      r.kept = kept;
      r.belt_x = 18'(b[0]);
      r.belt_y = 18'(b[1]);
      r.belt_z = 18'(b[2]);
      r.done = p.last;
      r.accepted = p.last && (frame_kept > min_points_set);
      r.count = frame_kept;
      if (p.last) frame_kept = '0;
      return r;
   endfunction

   function automatic camera_point_type make_point(input int x, input int y, input int z,
                                                   input bit v, input bit l);
      camera_point_type p;
      p.px = 17'(x);
      p.py = 17'(y);
      p.pz = 17'(z);
      p.valid = v;
      p.last = l;
      return p;
   endfunction

   function automatic camera_point_type random_point();
      camera_point_type p;
      if ($urandom_range(0, 99) < 80) begin
         p.px = 17'(int'($urandom_range(0, 24000)) - 12000);
         p.py = 17'(int'($urandom_range(0, 24000)) - 12000);
         p.pz = 17'($urandom_range(DEPTH_FLOOR + 1, DEPTH_CEIL - 1));
         p.valid = 1'b1;
      end else begin
         p.px = 17'($urandom);
         p.py = 17'($urandom);
         p.pz = 17'($urandom);
         p.valid = 1'($urandom);
      end
      p.last = ($urandom_range(0, 15) == 0);
      return p;
   endfunction

   function automatic int random_gap();
      int r;
      if (!tx_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [18:0] quat_word(input int v);
      return {3'($urandom), 16'(v)};
   endfunction

   function automatic logic [18:0] shift_word(input int v);
      return {2'($urandom), 17'(v)};
   endfunction

   task automatic send_point(input camera_point_type p);
      int gap;
      belt_result_type want;
      gap = random_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x = p.px;
      req_pos_y = p.py;
      req_pos_z = p.pz;
      req_point_valid = p.valid;
      req_frame_last = p.last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      want = predict_crop(p);
      expected_belt_results.insert(expected_belt_results.size(), want);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_belt_results.size() != 0) @(negedge clock);
   endtask

   // A quaternion write starts a matrix rebuild; the block holds req_ready low until it is done.
   task automatic write_reg(input pchc_pkg::csr_reg_type which, input logic [18:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = which;
      csr_wdata = value;
      apply_setting(which, value);
      @(negedge clock);
      csr_write_en = 1'b0;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
   endtask

   task automatic load_random_setup(input int style);
      int qmax [5];
      int smax [3];
      int nmax [3];
      qmax = '{-16384, 16384, 0, -32768, 32767};
      smax = '{-65536, 65535, 0};
      nmax = '{0, 262144, 524287};
      wait_results_drained();
      case (style)
         0: begin
            write_reg(pchc_pkg::CSR_QUAT_W, quat_word(16384 - int'($urandom_range(0, 800))));
            write_reg(pchc_pkg::CSR_QUAT_X, quat_word(int'($urandom_range(0, 3000)) - 1500));
            write_reg(pchc_pkg::CSR_QUAT_Y, quat_word(int'($urandom_range(0, 3000)) - 1500));
            write_reg(pchc_pkg::CSR_QUAT_Z, quat_word(int'($urandom_range(0, 3000)) - 1500));
            write_reg(pchc_pkg::CSR_SHIFT_X,
                      shift_word(int'($urandom_range(0, 8000)) - 4000));
            write_reg(pchc_pkg::CSR_SHIFT_Y,
                      shift_word(int'($urandom_range(0, 8000)) - 4000));
            write_reg(pchc_pkg::CSR_SHIFT_Z, shift_word($urandom_range(8000, 11000)));
            write_reg(pchc_pkg::CSR_MIN_POINTS, 19'($urandom_range(0, 12)));
         end
         1: begin
            write_reg(pchc_pkg::CSR_QUAT_W,
                      quat_word(int'($urandom_range(0, 32768)) - 16384));
            write_reg(pchc_pkg::CSR_QUAT_X,
                      quat_word(int'($urandom_range(0, 32768)) - 16384));
            write_reg(pchc_pkg::CSR_QUAT_Y,
                      quat_word(int'($urandom_range(0, 32768)) - 16384));
            write_reg(pchc_pkg::CSR_QUAT_Z,
                      quat_word(int'($urandom_range(0, 32768)) - 16384));
            write_reg(pchc_pkg::CSR_SHIFT_X, shift_word($urandom));
            write_reg(pchc_pkg::CSR_SHIFT_Y, shift_word($urandom));
            write_reg(pchc_pkg::CSR_SHIFT_Z, shift_word($urandom));
            write_reg(pchc_pkg::CSR_MIN_POINTS, 19'($urandom_range(0, 4)));
         end
         default: begin
            write_reg(pchc_pkg::CSR_QUAT_W, quat_word(qmax[$urandom_range(0, 4)]));
            write_reg(pchc_pkg::CSR_QUAT_X, quat_word(qmax[$urandom_range(0, 4)]));
            write_reg(pchc_pkg::CSR_QUAT_Y, quat_word(qmax[$urandom_range(0, 4)]));
            write_reg(pchc_pkg::CSR_QUAT_Z, quat_word(qmax[$urandom_range(0, 4)]));
            write_reg(pchc_pkg::CSR_SHIFT_X, shift_word(smax[$urandom_range(0, 2)]));
            write_reg(pchc_pkg::CSR_SHIFT_Y, shift_word(smax[$urandom_range(0, 2)]));
            write_reg(pchc_pkg::CSR_SHIFT_Z, shift_word(smax[$urandom_range(0, 2)]));
            write_reg(pchc_pkg::CSR_MIN_POINTS, 19'(nmax[$urandom_range(0, 2)]));
         end
      endcase
   endtask

   task automatic test_depth_window();
      send_point(make_point(0, 0, 7782, 1, 0));
      send_point(make_point(0, 0, 7783, 1, 0));
      send_point(make_point(-65536, 65535, 12943, 1, 0));
      send_point(make_point(65535, -65536, 12944, 1, 0));
      send_point(make_point(100, 100, 10000, 0, 0));
      send_point(make_point(0, 0, -65536, 1, 0));
      send_point(make_point(0, 0, 65535, 1, 1));
   endtask

   task automatic test_height_window();
      wait_results_drained();
      write_reg(pchc_pkg::CSR_SHIFT_Z, 19'(7500));
      write_reg(pchc_pkg::CSR_MIN_POINTS, 19'(2));
      send_point(make_point(0, 0, 7868, 1, 0));
      send_point(make_point(0, 0, 7869, 1, 0));
      send_point(make_point(0, 0, 10367, 1, 0));
      send_point(make_point(0, 0, 10368, 1, 1));
      send_point(make_point(5, -5, 9000, 1, 0));
      send_point(make_point(0, 0, 9001, 1, 0));
      send_point(make_point(0, 0, 9002, 1, 1));
   endtask

   task automatic test_rotation_extremes();
      wait_results_drained();
      write_reg(pchc_pkg::CSR_QUAT_W, quat_word(-16384));
      write_reg(pchc_pkg::CSR_QUAT_X, quat_word(-16384));
      write_reg(pchc_pkg::CSR_QUAT_Y, quat_word(-16384));
      write_reg(pchc_pkg::CSR_QUAT_Z, quat_word(-16384));
      write_reg(pchc_pkg::CSR_SHIFT_X, shift_word(65535));
      write_reg(pchc_pkg::CSR_SHIFT_Y, shift_word(-65536));
      write_reg(pchc_pkg::CSR_SHIFT_Z, shift_word(-65536));
      write_reg(pchc_pkg::CSR_MIN_POINTS, 19'(0));
      send_point(make_point(-65536, 65535, 7800, 1, 0));
      send_point(make_point(65535, -65536, 12900, 1, 1));
      wait_results_drained();
      write_reg(pchc_pkg::CSR_QUAT_W, quat_word(0));
      write_reg(pchc_pkg::CSR_SHIFT_X, shift_word(0));
      write_reg(pchc_pkg::CSR_SHIFT_Y, shift_word(0));
      write_reg(pchc_pkg::CSR_SHIFT_Z, shift_word(9000));
      send_point(make_point(1000, -1000, 10000, 1, 1));
      wait_results_drained();
      write_reg(pchc_pkg::CSR_QUAT_W, quat_word(16384));
      write_reg(pchc_pkg::CSR_QUAT_X, quat_word(16384));
      send_point(make_point(-20000, 20000, 11000, 1, 1));
   endtask

   task automatic test_random_frames();
      int phase;
      int n;
      for (phase = 0; phase < PHASES; phase++) begin
         load_random_setup((phase == 2 || phase == 6) ? 1 : (phase == 4 ? 2 : 0));
         tx_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
         rx_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
         for (n = 0; n < PHASE_POINTS; n++) send_point(random_point());
      end
   endtask

   task automatic test_output_stall();
      int n;
      load_random_setup(0);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      @(negedge clock);
      rx_hold_request = 300;
      for (n = 0; n < 40; n++) send_point(random_point());
   endtask

   task automatic test_input_pause();
      int n;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      for (n = 0; n < 60; n++) send_point(random_point());
      wait_results_drained();
      for (n = 0; n < 60; n++) send_point(random_point());
   endtask

   always @(negedge clock) begin
      if (rx_hold_request > 0) begin
         rx_stall_left = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_stall_left > 0) begin
         rsp_ready = 1'b0;
         rx_stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 99) < 12) begin
         rsp_ready = 1'b0;
         rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      belt_result_type got;
      belt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kept = rsp_point_kept;
         got.belt_x = rsp_belt_x;
         got.belt_y = rsp_belt_y;
         got.belt_z = rsp_belt_z;
         got.done = rsp_frame_done;
         got.accepted = rsp_frame_accepted;
         got.count = rsp_frame_count;
         if (expected_belt_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result transaction: kept=%0b x=%0d y=%0d z=%0d",
                        got.kept, got.belt_x, got.belt_y, got.belt_z);
         end else begin
            want = expected_belt_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch expected: kept=%0b x=%0d y=%0d z=%0d done=%0b acc=%0b cnt=%0d",
                           want.kept, want.belt_x, want.belt_y, want.belt_z, want.done,
                           want.accepted, want.count);
                  $display("         actual:   kept=%0b x=%0d y=%0d z=%0d done=%0b acc=%0b cnt=%0d",
                           got.kept, got.belt_x, got.belt_y, got.belt_z, got.done,
                           got.accepted, got.count);
               end
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_point_valid = 1'b0;
      req_frame_last = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      rx_stall_left = 0;
      rx_hold_request = 0;
      rx_idle_on = 1'b1;
      tx_idle_on = 1'b1;
      restore_defaults();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_depth_window();
      test_height_window();
      test_rotation_extremes();
      test_random_frames();
      test_output_stall();
      test_input_pause();

      wait_results_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_belt_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
